### design/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and codes of the three-component vector unit
// Transfer payloads, opcode codes and the data carried by the root cells.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

  // Magnitudes are normalized into a fixed 32-bit frame; their squares sum
  // into 64 bits.
  localparam int MAG_W      = 32;
  localparam int SUM_W      = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_SQLEN = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [63:0] res_scalar;
    logic               saturated;
    logic               zero_input;
  } out_item_t;

  // Result finished early, plus a mark that the divider lanes supply it.
  typedef struct packed {
    out_item_t item;
    logic      use_norm;
  } side_t;

  // Working set of one square-root cell.
  typedef struct packed {
    logic [SUM_W-1:0]      s;
    logic [SUM_W-1:0]      res;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } sqrt_data_t;

endpackage

`default_nettype wire

### design/v3n_front.sv
// ----------------------------------------------------------------------------
// v3n_front: operand stages of the vector unit
// Five stages: operand capture, products and sums, saturation and magnitude
// normalization, squares, sum of squares feeding the root chain.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_front
  import v3n_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       en,
  input  in_item_t   item,
  output side_t      side,
  output sqrt_data_t seed
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * CW;
  localparam int SW = 2 * CW + 2;
  localparam logic signed [SW-1:0] VEC_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] VEC_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] SCL_MAX = {3'b000, {(PW-1){1'b1}}};
  localparam logic signed [SW-1:0] SCL_MIN = {3'b111, {(PW-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] ONE     = SW'(1) <<< FRAC_BITS;

  function automatic logic [CW:0] sat_vec(input logic signed [SW-1:0] v);
    logic [CW:0] r;
    if (v > VEC_MAX) begin
      r = {1'b1, VEC_MAX[CW-1:0]};
    end else if (v < VEC_MIN) begin
      r = {1'b1, VEC_MIN[CW-1:0]};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

  function automatic logic [PW:0] sat_scl(input logic signed [SW-1:0] v);
    logic [PW:0] r;
    if (v > SCL_MAX) begin
      r = {1'b1, SCL_MAX[PW-1:0]};
    end else if (v < SCL_MIN) begin
      r = {1'b1, SCL_MIN[PW-1:0]};
    end else begin
      r = {1'b0, v[PW-1:0]};
    end
    return r;
  endfunction

  // stage 1: operands cut to CW bits
  logic [2:0]           s1_op;
  logic signed [CW-1:0] s1_a [3];
  logic signed [CW-1:0] s1_b [3];
  logic signed [CW-1:0] s1_k;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= item.opcode;
      s1_a[0] <= item.a_x[CW-1:0];
      s1_a[1] <= item.a_y[CW-1:0];
      s1_a[2] <= item.a_z[CW-1:0];
      s1_b[0] <= item.b_x[CW-1:0];
      s1_b[1] <= item.b_y[CW-1:0];
      s1_b[2] <= item.b_z[CW-1:0];
      s1_k    <= item.scale_factor[CW-1:0];
    end
  end

  // stage 2: one multiplier per lane, shared by scale, dot and squared length
  logic signed [CW-1:0] mul_b [3];
  logic signed [PW-1:0] prod  [3];
  logic signed [CW:0]   sum_ab [3];
  logic [CW-1:0]        mag_a [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s1_op == OP_SCALE) begin
        mul_b[i] = s1_k;
      end else if (s1_op == OP_DOT) begin
        mul_b[i] = s1_b[i];
      end else begin
        mul_b[i] = s1_a[i];
      end
      prod[i] = PW'(s1_a[i]) * PW'(mul_b[i]);
      if (s1_op == OP_SUB) begin
        sum_ab[i] = (CW+1)'(s1_a[i]) - (CW+1)'(s1_b[i]);
      end else begin
        sum_ab[i] = (CW+1)'(s1_a[i]) + (CW+1)'(s1_b[i]);
      end
      mag_a[i] = s1_a[i][CW-1] ? CW'(-s1_a[i]) : CW'(s1_a[i]);
    end
  end

  logic [2:0]           s2_op;
  logic signed [PW-1:0] s2_prod [3];
  logic signed [CW:0]   s2_sum  [3];
  logic [MAG_W-1:0]     s2_mag  [3];
  logic [2:0]           s2_neg;
  logic                 s2_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op   <= s1_op;
      s2_zero <= (s1_a[0] == '0) && (s1_a[1] == '0) && (s1_a[2] == '0);
      for (int i = 0; i < 3; i++) begin
        s2_prod[i] <= prod[i];
        s2_sum[i]  <= sum_ab[i];
        s2_mag[i]  <= MAG_W'(mag_a[i]);
        s2_neg[i]  <= s1_a[i][CW-1];
      end
    end
  end

  // stage 3: saturation of the direct results, magnitude normalization
  logic [CW:0]           vr [3];
  logic [PW:0]           sr;
  logic signed [SW-1:0]  dsum;
  side_t                 side_n;
  logic [MAG_W-1:0]      mx;
  logic [MAG_W-1:0]      nm [3];

  always_comb begin
    side_n = '0;
    sr     = '0;
    dsum   = SW'(s2_prod[0]) + SW'(s2_prod[1]) + SW'(s2_prod[2]);
    for (int i = 0; i < 3; i++) begin
      vr[i] = '0;
    end
    unique case (s2_op)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          vr[i] = sat_vec(SW'(s2_sum[i]));
        end
      end
      OP_SCALE: begin
        // round half up, then floor shift
        for (int i = 0; i < 3; i++) begin
          vr[i] = sat_vec((SW'(s2_prod[i]) + HALF) >>> FRAC_BITS);
        end
      end
      OP_DOT, OP_SQLEN: begin
        sr = sat_scl(dsum);
      end
      OP_NORM: begin
        if (s2_zero) begin
          vr[0] = sat_vec(ONE);
          side_n.item.zero_input = 1'b1;
        end else begin
          side_n.use_norm = 1'b1;
        end
      end
      default: begin
      end
    endcase
    side_n.item.res_x      = 32'(signed'(vr[0][CW-1:0]));
    side_n.item.res_y      = 32'(signed'(vr[1][CW-1:0]));
    side_n.item.res_z      = 32'(signed'(vr[2][CW-1:0]));
    side_n.item.res_scalar = 64'(signed'(sr[PW-1:0]));
    side_n.item.saturated  = vr[0][CW] | vr[1][CW] | vr[2][CW] | sr[PW];
  end

  // left shift until the largest magnitude lies in [2^30, 2^31]
  always_comb begin
    mx = s2_mag[0];
    if (s2_mag[1] > mx) begin
      mx = s2_mag[1];
    end
    if (s2_mag[2] > mx) begin
      mx = s2_mag[2];
    end
    for (int i = 0; i < 3; i++) begin
      nm[i] = s2_mag[i];
    end
    for (int st = $clog2(MAG_W) - 1; st >= 0; st--) begin
      if (mx < (MAG_W'(1) << (MAG_W - 1 - (1 << st)))) begin
        mx = mx << (1 << st);
        for (int i = 0; i < 3; i++) begin
          nm[i] = nm[i] << (1 << st);
        end
      end
    end
  end

  side_t            s3_side;
  logic [MAG_W-1:0] s3_mag [3];
  logic [2:0]       s3_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= side_n;
      s3_neg  <= s2_neg;
      for (int i = 0; i < 3; i++) begin
        s3_mag[i] <= nm[i];
      end
    end
  end

  // stage 4: squares
  side_t            s4_side;
  logic [MAG_W-1:0] s4_mag [3];
  logic [2:0]       s4_neg;
  logic [SUM_W-1:0] s4_sq  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= s3_side;
      s4_neg  <= s3_neg;
      for (int i = 0; i < 3; i++) begin
        s4_mag[i] <= s3_mag[i];
        s4_sq[i]  <= SUM_W'(s3_mag[i]) * SUM_W'(s3_mag[i]);
      end
    end
  end

  // stage 5: sum of squares, seed of the root chain
  always_ff @(posedge clk) begin
    if (en) begin
      side     <= s4_side;
      seed.s   <= s4_sq[0] + s4_sq[1] + s4_sq[2];
      seed.res <= '0;
      seed.neg <= s4_neg;
      for (int i = 0; i < 3; i++) begin
        seed.mag[i] <= s4_mag[i];
      end
    end
  end

endmodule

`default_nettype wire

### design/v3n_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one step of the integer square root chain
// Tries one result bit per cell and hands the remainder on.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqrt_cell
  import v3n_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       en,
  input  sqrt_data_t d_in,
  output sqrt_data_t d_out
);

  localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * STEP);

  logic [SUM_W:0] trial;
  sqrt_data_t     d_out_next;

  always_comb begin
    d_out_next = d_in;
    trial      = {1'b0, d_in.res} + {1'b0, BIT};
    if ({1'b0, d_in.s} >= trial) begin
      d_out_next.s   = d_in.s - trial[SUM_W-1:0];
      d_out_next.res = (d_in.res >> 1) + BIT;
    end else begin
      d_out_next.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_out_next;
    end
  end

endmodule

`default_nettype wire

### design/v3n_div_cell.sv
// ----------------------------------------------------------------------------
// v3n_div_cell: one quotient bit of the three normalize dividers
// Restoring step on three lanes that share the divisor (the length).
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_div_cell
  import v3n_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int BIT_POS   = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [2:0][MAG_W+FRAC_BITS:0]     rem_in,
  input  logic [2:0][FRAC_BITS:0]           quo_in,
  input  logic [MAG_W-1:0]                  len_in,
  input  logic [2:0]                        neg_in,
  output logic [2:0][MAG_W+FRAC_BITS:0]     rem_out,
  output logic [2:0][FRAC_BITS:0]           quo_out,
  output logic [MAG_W-1:0]                  len_out,
  output logic [2:0]                        neg_out
);

  localparam int RW = MAG_W + FRAC_BITS + 1;

  logic [RW-1:0]                   dvs;
  logic [2:0][RW-1:0]              rem_out_next;
  logic [2:0][FRAC_BITS:0]         quo_out_next;

  always_comb begin
    dvs          = RW'(len_in) << BIT_POS;
    rem_out_next = rem_in;
    quo_out_next = quo_in;
    for (int i = 0; i < 3; i++) begin
      if (rem_in[i] >= dvs) begin
        rem_out_next[i]          = rem_in[i] - dvs;
        quo_out_next[i][BIT_POS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_out_next;
      quo_out <= quo_out_next;
      len_out <= len_in;
      neg_out <= neg_in;
    end
  end

endmodule

`default_nettype wire

### design/vector3_alu_normalize_unit.sv
// ----------------------------------------------------------------------------
// vector3_alu_normalize_unit: fixed-point three-component vector unit
//
// Input channel item/item_valid/item_stall carries an opcode, vectors A and B
// and a scalar; output channel result/result_valid/result_stall carries one
// result per input transfer, in order. Ops: add, subtract, scale, dot,
// squared length, normalize (zero vector gives (1,0,0) and zero_input).
// Throughput: one transfer per cycle while item_stall is low. Every item
// walks the same pipe: five operand stages, a chain of 32 square-root
// cells, a divider setup stage and FRAC_BITS+1 divider cells, one quotient
// bit per cell on three lanes, followed by the output register.
// Stall: the output register is backed by a one-entry skid register. When the
// receiver stalls, one more item lands in the skid, then item_stall rises
// and the whole pipe holds until the skid drains. item_stall is registered.
// Reset (rst, synchronous) empties the pipe, the output and the skid; the
// unit has no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_alu_normalize_unit
  import v3n_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam int CW           = COMPONENT_WIDTH;
  localparam int RW           = MAG_W + FRAC_BITS + 1;   // divider remainder
  localparam int QW           = FRAC_BITS + 1;           // quotient never exceeds 1.0
  localparam int DIV_STEPS    = FRAC_BITS + 1;
  localparam int FRONT_STAGES = 5;
  localparam int SIDE_D       = SQRT_STEPS + 1 + DIV_STEPS;
  localparam int DEPTH        = FRONT_STAGES + SIDE_D;
  localparam int FW           = QW + CW + 1;             // signed quotient before clamp
  localparam logic signed [FW-1:0] NRM_MAX = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [FW-1:0] NRM_MIN = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // Pipe advance: everything moves unless the skid holds an item.
  logic en;
  logic accept;
  logic skid_valid;
  assign en         = !skid_valid;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;

  // One valid bit per stage.
  logic [DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  // Operand stages.
  side_t      side_front;
  sqrt_data_t sq_chain [SQRT_STEPS+1];

  v3n_front #(
    .FRAC_BITS       (FRAC_BITS),
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_front (
    .clk  (clk),
    .en   (en),
    .item (item),
    .side (side_front),
    .seed (sq_chain[0])
  );

  // Square-root chain: one result bit per cell.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    v3n_sqrt_cell #(
      .STEP (g)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_chain[g]),
      .d_out (sq_chain[g+1])
    );
  end

  // Divider setup: numerator is mag << FRAC_BITS plus half the length,
  // which rounds each quotient to nearest.
  logic [MAG_W-1:0]    root_len;
  logic [2:0][RW-1:0]  prep_rem;
  logic [MAG_W-1:0]    prep_len;
  logic [2:0]          prep_neg;

  assign root_len = sq_chain[SQRT_STEPS].res[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prep_len <= root_len;
      prep_neg <= sq_chain[SQRT_STEPS].neg;
      for (int i = 0; i < 3; i++) begin
        prep_rem[i] <= (RW'(sq_chain[SQRT_STEPS].mag[i]) << FRAC_BITS) + RW'(root_len >> 1);
      end
    end
  end

  // Divider chain, most significant quotient bit first.
  logic [2:0][RW-1:0] dv_rem [DIV_STEPS+1];
  logic [2:0][QW-1:0] dv_quo [DIV_STEPS+1];
  logic [MAG_W-1:0]   dv_len [DIV_STEPS+1];
  logic [2:0]         dv_neg [DIV_STEPS+1];

  assign dv_rem[0] = prep_rem;
  assign dv_quo[0] = '0;
  assign dv_len[0] = prep_len;
  assign dv_neg[0] = prep_neg;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    v3n_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BIT_POS   (FRAC_BITS - g)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (dv_rem[g]),
      .quo_in  (dv_quo[g]),
      .len_in  (dv_len[g]),
      .neg_in  (dv_neg[g]),
      .rem_out (dv_rem[g+1]),
      .quo_out (dv_quo[g+1]),
      .len_out (dv_len[g+1]),
      .neg_out (dv_neg[g+1])
    );
  end

  // Results that do not need the root travel alongside the chains.
  side_t side_line [SIDE_D];
  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= side_front;
      for (int j = 1; j < SIDE_D; j++) begin
        side_line[j] <= side_line[j-1];
      end
    end
  end

  // Final merge: signed, clamped quotients for a normalize.
  logic signed [FW-1:0] nq  [3];
  logic signed [CW-1:0] nv  [3];
  logic [2:0]           nsat;
  out_item_t            fin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i] = signed'(FW'(dv_quo[DIV_STEPS][i]));
      if (dv_neg[DIV_STEPS][i]) begin
        nq[i] = -nq[i];
      end
      nsat[i] = 1'b1;
      if (nq[i] > NRM_MAX) begin
        nv[i] = NRM_MAX[CW-1:0];
      end else if (nq[i] < NRM_MIN) begin
        nv[i] = NRM_MIN[CW-1:0];
      end else begin
        nv[i]   = nq[i][CW-1:0];
        nsat[i] = 1'b0;
      end
    end
    fin = side_line[SIDE_D-1].item;
    if (side_line[SIDE_D-1].use_norm) begin
      fin.res_x      = 32'(nv[0]);
      fin.res_y      = 32'(nv[1]);
      fin.res_z      = 32'(nv[2]);
      fin.res_scalar = '0;
      fin.saturated  = |nsat;
      fin.zero_input = 1'b0;
    end
  end

  // Output register with skid.
  logic      last_valid;
  logic      out_free;
  out_item_t skid;

  assign last_valid = vld[DEPTH-1];
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (out_free) begin
      result_valid <= last_valid;
    end else if (last_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        result <= skid;
      end
    end else if (out_free) begin
      if (last_valid) begin
        result <= fin;
      end
    end else if (last_valid) begin
      skid <= fin;
    end
  end

`ifndef SYNTHESIS
  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds an item with no result waiting");

  // a stalled output keeps the skid occupied
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && result_stall |=> skid_valid)
    else $error("skid drained while output stalled");

  // zero vector normalize leaves only x
  a_zero_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_input |->
      result.res_y == 0 && result.res_z == 0 && result.res_scalar == 0)
    else $error("zero-vector result carries y, z or scalar");

  // scalar and vector results never both carry data
  a_scalar_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.res_scalar != 0 |->
      result.res_x == 0 && result.res_y == 0 && result.res_z == 0)
    else $error("scalar result with nonzero vector fields");
`endif

endmodule

`default_nettype wire

### tb/vector3_alu_normalize_unit_tb.sv
// ----------------------------------------------------------------------------
// vector3_alu_normalize_unit_tb: self-checking bench for the vector unit
// Drives add, subtract, scale, dot, squared length, normalize and unused-opcode items with
// random idle and stall bursts, predicts each result and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector3_alu_normalize_unit_tb;
  import v3n_pkg::*;

  localparam int FRAC  = 16;
  localparam int LAT   = 39 + FRAC;
  localparam int LIMIT = 400000;

  // Scoreboard: predicts results for accepted items, checks them in order.
  class vec_scoreboard;
    out_item_t pending[$];
    int        errors;
    int        checked;
    int        op_seen[8];

    function logic signed [31:0] clamp32(logic signed [127:0] v, ref logic flag);
      if (v > 128'sh7fffffff) begin
        flag = 1'b1;
        return 32'sh7fffffff;
      end
      if (v < -128'sh80000000) begin
        flag = 1'b1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    function logic [63:0] root64(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s   = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function out_item_t compute(in_item_t it);
      out_item_t           o;
      logic signed [127:0] a[3], b[3], k, p, acc;
      logic [63:0]         mag[3], m, s, len, q;
      logic                sat;
      o   = '0;
      sat = 1'b0;
      a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
      b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
      k = it.scale_factor;
      case (it.opcode)
        OP_ADD, OP_SUB: begin
          o.res_x = clamp32(it.opcode == OP_ADD ? a[0] + b[0] : a[0] - b[0], sat);
          o.res_y = clamp32(it.opcode == OP_ADD ? a[1] + b[1] : a[1] - b[1], sat);
          o.res_z = clamp32(it.opcode == OP_ADD ? a[2] + b[2] : a[2] - b[2], sat);
        end
        OP_SCALE: begin
          // round half up: add half an LSB, arithmetic shift floors
          p = (a[0] * k + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
          o.res_x = clamp32(p, sat);
          p = (a[1] * k + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
          o.res_y = clamp32(p, sat);
          p = (a[2] * k + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
          o.res_z = clamp32(p, sat);
        end
        OP_DOT, OP_SQLEN: begin
          acc = 0;
          for (int i = 0; i < 3; i++)
            acc = acc + a[i] * (it.opcode == OP_DOT ? b[i] : a[i]);
          if (acc > 128'sh7fffffffffffffff) begin
            sat = 1'b1;
            o.res_scalar = 64'sh7fffffffffffffff;
          end else if (acc < -128'sh8000000000000000) begin
            sat = 1'b1;
            o.res_scalar = 64'sh8000000000000000;
          end else begin
            o.res_scalar = acc[63:0];
          end
        end
        OP_NORM: begin
          m = 0;
          for (int i = 0; i < 3; i++) begin
            mag[i] = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
            if (mag[i] > m) m = mag[i];
          end
          if (m == 0) begin
            o.zero_input = 1'b1;
            o.res_x = clamp32(128'sd1 <<< FRAC, sat);
          end else begin
            while (m < (64'd1 << 30)) begin
              m = m << 1;
              for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            s = 0;
            for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
            len = root64(s);
            for (int i = 0; i < 3; i++) begin
              q = ((mag[i] << FRAC) + (len >> 1)) / len;
              p = a[i] < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q});
              if (i == 0) o.res_x = clamp32(p, sat);
              if (i == 1) o.res_y = clamp32(p, sat);
              if (i == 2) o.res_z = clamp32(p, sat);
            end
          end
        end
        default: ;
      endcase
      o.saturated = sat;
      return o;
    endfunction

    function void note_item(in_item_t it);
      pending.push_back(compute(it));
      op_seen[it.opcode]++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.res_x !== want.res_x) begin
        errors++;
        $display("%0t: res_x exp %h got %h", $time, want.res_x, got.res_x);
      end
      if (got.res_y !== want.res_y) begin
        errors++;
        $display("%0t: res_y exp %h got %h", $time, want.res_y, got.res_y);
      end
      if (got.res_z !== want.res_z) begin
        errors++;
        $display("%0t: res_z exp %h got %h", $time, want.res_z, got.res_z);
      end
      if (got.res_scalar !== want.res_scalar) begin
        errors++;
        $display("%0t: res_scalar exp %h got %h", $time, want.res_scalar,
                 got.res_scalar);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated exp %b got %b", $time, want.saturated,
                 got.saturated);
      end
      if (got.zero_input !== want.zero_input) begin
        errors++;
        $display("%0t: zero_input exp %b got %b", $time, want.zero_input,
                 got.zero_input);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  vec_scoreboard sb = new();
  int  cycles = 0;
  bit  quiet = 1'b0;    // no idling in the closing stretch
  bit  stall_on = 1'b1;

  vector3_alu_normalize_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #10 clk = ~clk;

  // Cycle limit guards against a hung pipe.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: check every transfer, stall in random bursts.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(result);
  end

  initial begin : stall_gen
    int n;
    @(posedge clk);
    forever begin
      if (quiet || !stall_on) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 11);
        result_stall <= ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  // One input transfer; payload holds while stalled.
  task automatic send(in_item_t it);
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  // Random idle burst between transfers.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_comp(int shape);
    case (shape)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return 0;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int shape;
    shape = $urandom_range(0, 4);
    it.opcode = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
    it.a_x = rand_comp(shape);
    it.a_y = rand_comp($urandom_range(0, 4));
    it.a_z = rand_comp(shape);
    it.b_x = rand_comp($urandom_range(0, 4));
    it.b_y = rand_comp($urandom_range(0, 4));
    it.b_z = rand_comp($urandom_range(0, 4));
    it.scale_factor = rand_comp($urandom_range(0, 3));
    return it;
  endfunction

  initial begin : main
    in_item_t it;
    int wait_cnt;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each opcode at the extremes, zero vector, tiny vectors.
    for (int op = 0; op < 8; op++) begin
      it = '{3'(op), 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000};
      send(it);
    end
    send('{OP_NORM, 0, 0, 0, 32'hffffffff, 1, 2, 3});
    send('{OP_NORM, 1, 0, 0, 0, 0, 0, 0});
    send('{OP_NORM, 0, -1, 0, 0, 0, 0, 0});
    send('{OP_NORM, 3, 4, 0, 0, 0, 0, 0});
    send('{OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0});
    send('{OP_SCALE, 1, -1, 3, 0, 0, 0, 32'h00008000});      // rounding ties
    send('{OP_SCALE, 32'h00010000, -32'sh10000, 5, 0, 0, 0, 32'h7fffffff});
    send('{OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000, 32'h80000000, 32'h80000000, 0});
    send('{OP_SQLEN, 0, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0});
    send('{OP_ADD, 32'hffffffff, 0, 1, 32'hffffffff, 0, 32'hffffffff, 0});
    send('{OP_SUB, 32'h80000000, 0, 32'h7fffffff, 1, 0, 32'hffffffff, 0});

    // Hold off until the pipe drains once.
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < 1750; n++) begin
      if (n == 1500) quiet = 1'b1;
      if (n == 700) begin
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      maybe_idle();
      send(rand_item());
    end
    item_valid <= 1'b0;

    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LAT + 10) @(posedge clk);

    $display("checked %0d results: add %0d sub %0d scale %0d dot %0d sqlen %0d",
             sb.checked, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2],
             sb.op_seen[3], sb.op_seen[4]);
    $display("normalize %0d, unused opcodes %0d", sb.op_seen[5],
             sb.op_seen[6] + sb.op_seen[7]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### vector3_alu_normalize_unit.f
design/v3n_pkg.sv
design/v3n_front.sv
design/v3n_sqrt_cell.sv
design/v3n_div_cell.sv
design/vector3_alu_normalize_unit.sv
tb/vector3_alu_normalize_unit_tb.sv
